// ===== src/fire_box_blur_3x3_assert.svh =====
// Assertion macros for the fire box blur block.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef FIRE_BOX_BLUR_3X3_ASSERT_SVH
`define FIRE_BOX_BLUR_3X3_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fbb_pkg.sv =====
// Shared types, constants and the divide-by-ten helper for the fire box blur.
// No dependencies.
package fbb_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SUM_W      = 12;
  localparam int LEN_CFG_W  = 10;
  localparam int CNT_CFG_W  = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int MIN_DIM    = 3;

  localparam logic [LEN_CFG_W-1:0] LEN_RESET = 10'd145;
  localparam logic [CNT_CFG_W-1:0] CNT_RESET = 11'd257;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_LENGTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_COUNT  = 1'b1;

  // Reciprocal of ten in Q15; exact truncation for sums up to 9 * 255.
  localparam logic [SUM_W-1:0] DIV10_RECIP = 12'd3277;
  localparam int               DIV10_SHIFT = 15;
  localparam logic [CH_W-1:0]  MAX_BLUR    = 8'd229;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // One new column of the 3x3 window: two lines up, one line up, current.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t pix;
  } win_col_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum3_t;

  // Truncating divide by ten through a reciprocal multiply.
  function automatic logic [CH_W-1:0] div10(input logic [SUM_W-1:0] s);
    logic [2*SUM_W-1:0] prod;
    prod = s * DIV10_RECIP;
    return prod[DIV10_SHIFT +: CH_W];
  endfunction

endpackage

// ===== src/fbb_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
module fbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents when both ports hit the same entry.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/fbb_window.sv =====
// Six window registers of the 3x3 neighborhood and the nine-pixel channel sums.
// Depends on fbb_pkg.
module fbb_window import fbb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     shift_en,
  input  win_col_t col,
  output sum3_t    sums
);

  // Entries 0..2 hold the previous column, 3..5 the one before it.
  pix_t win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= col.top;
      win_r[1] <= col.mid;
      win_r[2] <= col.pix;
    end
  end

  // Nine-term sums per channel over the new column and the stored two.
  always_comb begin
    sums.red   = SUM_W'(col.top.red) + SUM_W'(col.mid.red) + SUM_W'(col.pix.red);
    sums.green = SUM_W'(col.top.green) + SUM_W'(col.mid.green) + SUM_W'(col.pix.green);
    sums.blue  = SUM_W'(col.top.blue) + SUM_W'(col.mid.blue) + SUM_W'(col.pix.blue);
    for (int i = 0; i < 6; i++) begin
      sums.red   = sums.red + SUM_W'(win_r[i].red);
      sums.green = sums.green + SUM_W'(win_r[i].green);
      sums.blue  = sums.blue + SUM_W'(win_r[i].blue);
    end
  end

endmodule

// ===== src/fire_box_blur_3x3.sv =====
// Top level of the 3x3 box blur (sum of nine divided by ten) for a pixel stream.
// Depends on fbb_pkg, fbb_ram, fbb_window and fire_box_blur_3x3_assert.svh.
//
// Usage: pixels enter in scan order on the in_ stream, one per beat; in_tuser
// marks the first pixel of a frame and clears the line and position counters.
// Every pixel at line >= 2 and position >= 2 completes a 3x3 window and yields
// one beat on the out_ stream: the blurred center pixel and its coordinates.
// Border pixels produce no beat. line_length and line_count are written on the
// cfg_ port while the block is idle; out-of-range values are clamped.
// A result passes from stage one through the sum stage to the output register.
// Throughput: one pixel per clock while out_tready is high. Each pixel reads
// both line stores at its position and writes them back as it leaves stage one;
// a write that meets a read of the same entry is forwarded, so the single
// read/write pair per store sets the rate. When out_tready is low, the result
// holds in the output register, a second waits in the sum stage and a third in
// stage one; in_tready drops while that third is stuck; border pixels flow on.
// Reset clears the counters, the window registers, the pipeline valids and
// restores the default registers; the line stores are not cleared.
`include "fire_box_blur_3x3_assert.svh"

module fire_box_blur_3x3 import fbb_pkg::*; #(
  parameter int MAX_LINE_LENGTH = 512,
  parameter int MAX_LINE_COUNT  = 1024,
  localparam int PW       = $clog2(MAX_LINE_LENGTH),
  localparam int LW       = $clog2(MAX_LINE_COUNT),
  localparam int OUT_BITS = PIX_W + LW + PW,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Pixel input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,  // red_in, green_in, blue_in
  input  logic                  in_tuser,  // frame_start
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // red_out, green_out, blue_out, center_line, center_position, zero fill
  output logic [OUT_W-1:0]      out_tdata
);

  // Configuration registers.
  logic [LEN_CFG_W-1:0] line_length_r;
  logic [CNT_CFG_W-1:0] line_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LEN_RESET;
      line_count_r  <= CNT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LINE_LENGTH: line_length_r <= cfg_wdata[LEN_CFG_W-1:0];
        REG_LINE_COUNT:  line_count_r  <= cfg_wdata;
        default:         line_length_r <= line_length_r;
      endcase
    end
  end

  // Clamped frame dimensions.
  logic [PW:0] len_eff;
  logic [LW:0] cnt_eff;

  always_comb begin
    if (32'(line_length_r) < 32'(MIN_DIM)) begin
      len_eff = (PW+1)'(MIN_DIM);
    end else if (32'(line_length_r) > 32'(MAX_LINE_LENGTH)) begin
      len_eff = (PW+1)'(MAX_LINE_LENGTH);
    end else begin
      len_eff = (PW+1)'(line_length_r);
    end
    if (32'(line_count_r) < 32'(MIN_DIM)) begin
      cnt_eff = (LW+1)'(MIN_DIM);
    end else if (32'(line_count_r) > 32'(MAX_LINE_COUNT)) begin
      cnt_eff = (LW+1)'(MAX_LINE_COUNT);
    end else begin
      cnt_eff = (LW+1)'(line_count_r);
    end
  end

  // Pipeline handshake: S1 holds the read data, S2 the sums, then the output.
  logic  s1_valid_r, s1_emit_r, s1_fwd_r;
  logic  s2_valid_r, out_valid_r;
  logic  out_free, s2_take, s1_go, in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_take   = !s2_valid_r || out_free;
  assign s1_go     = s1_valid_r && (s2_take || !s1_emit_r);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  // Position and line counters.
  logic [PW-1:0] pos_r, pos_nxt, pos_cur;
  logic [LW-1:0] line_r, line_nxt, line_cur;
  logic          emit_cur;

  always_comb begin
    pos_cur  = in_tuser ? '0 : pos_r;
    line_cur = in_tuser ? '0 : line_r;
    emit_cur = (line_cur >= LW'(2)) && (pos_cur >= PW'(2));
    if ({1'b0, pos_cur} >= len_eff - (PW+1)'(1)) begin
      pos_nxt = '0;
      if ({1'b0, line_cur} >= cnt_eff - (LW+1)'(1)) begin
        line_nxt = '0;
      end else begin
        line_nxt = line_cur + LW'(1);
      end
    end else begin
      pos_nxt  = pos_cur + PW'(1);
      line_nxt = line_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      line_r <= '0;
    end else if (in_fire) begin
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
    end
  end

  // Line stores: store A holds the previous line, store B the one before it.
  pix_t in_pix;
  pix_t rd_a, rd_b;
  pix_t s1_pix_r, s1_fwd_top_r, s1_fwd_mid_r;
  pix_t s1_top, s1_mid;
  logic [PW-1:0] s1_idx_r;
  logic [LW-1:0] s1_line_r;
  logic [PW-1:0] s1_pos_r;

  assign in_pix.red   = in_tdata[CH_W-1:0];
  assign in_pix.green = in_tdata[2*CH_W-1:CH_W];
  assign in_pix.blue  = in_tdata[3*CH_W-1:2*CH_W];

  fbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE_LENGTH)
  ) u_store_a (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_idx_r),
    .wdata (s1_pix_r),
    .re    (in_fire),
    .raddr (pos_cur),
    .rdata (rd_a)
  );

  fbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE_LENGTH)
  ) u_store_b (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_idx_r),
    .wdata (s1_mid),
    .re    (in_fire),
    .raddr (pos_cur),
    .rdata (rd_b)
  );

  // Forwarded values replace stale read data when the write hit the same entry.
  assign s1_top = s1_fwd_r ? s1_fwd_top_r : rd_b;
  assign s1_mid = s1_fwd_r ? s1_fwd_mid_r : rd_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_emit_r    <= emit_cur;
      s1_idx_r     <= pos_cur;
      s1_pix_r     <= in_pix;
      s1_line_r    <= line_cur - LW'(1);
      s1_pos_r     <= pos_cur - PW'(1);
      s1_fwd_r     <= s1_go && (pos_cur == s1_idx_r);
      s1_fwd_top_r <= s1_mid;
      s1_fwd_mid_r <= s1_pix_r;
    end
  end

  // Window registers and nine-pixel sums.
  win_col_t s1_col;
  sum3_t    s1_sums;

  assign s1_col.top = s1_top;
  assign s1_col.mid = s1_mid;
  assign s1_col.pix = s1_pix_r;

  fbb_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_go),
    .col      (s1_col),
    .sums     (s1_sums)
  );

  // Sum stage.
  sum3_t         s2_sum_r;
  logic [LW-1:0] s2_line_r;
  logic [PW-1:0] s2_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_take) begin
      s2_valid_r <= s1_go && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_sum_r  <= s1_sums;
      s2_line_r <= s1_line_r;
      s2_pos_r  <= s1_pos_r;
    end
  end

  // Output register: divide by ten and hold until taken.
  pix_t          out_pix_r;
  logic [LW-1:0] out_line_r;
  logic [PW-1:0] out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_pix_r.red   <= div10(s2_sum_r.red);
      out_pix_r.green <= div10(s2_sum_r.green);
      out_pix_r.blue  <= div10(s2_sum_r.blue);
      out_line_r      <= s2_line_r;
      out_pos_r       <= s2_pos_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_pos_r, out_line_r, out_pix_r.blue,
                              out_pix_r.green, out_pix_r.red});

  // Checks on the pipeline.
  logic out_inner, out_in_range;

  assign out_inner    = (out_line_r != '0) && (out_pos_r != '0);
  assign out_in_range = (out_pix_r.red <= MAX_BLUR) && (out_pix_r.green <= MAX_BLUR) &&
                        (out_pix_r.blue <= MAX_BLUR);

  `FBB_ASSERT_IMP(a_center_inside, out_valid_r, out_inner, "result on border")
  `FBB_ASSERT_IMP(a_blur_range, out_valid_r, out_in_range, "blur out of range")
  `FBB_ASSERT_IMP(a_s1_from_read, $rose(s1_valid_r), $past(in_fire), "stage one without a read")

endmodule
